// File: hdl/wia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wia_pkg
// Shared opcodes, pipeline tag type and width helpers for the integer ALU.
// ----------------------------------------------------------------------------
package wia_pkg;

    localparam int WIA_DATA_WIDTH = 64;
    localparam int WIA_DIV_STAGES = 64;
    localparam int WIA_SH_STAGES  = 32;

    typedef enum logic [4:0] {
        OP_NEG, OP_NOT, OP_ADD, OP_SUB, OP_MUL,
        OP_DIV_S, OP_DIV_U, OP_REM_S, OP_REM_U,
        OP_AND, OP_OR, OP_XOR,
        OP_SHL, OP_SHR, OP_SAR, OP_ROTL, OP_ROTR,
        OP_EQ, OP_NE, OP_LT_S, OP_LT_U, OP_LE_S, OP_LE_U,
        OP_GT_S, OP_GT_U, OP_GE_S, OP_GE_U
    } wia_op_t;

    // sideband that rides along the divider stages
    typedef struct packed {
        logic [4:0]  op;
        logic [6:0]  w;
        logic        ok;
        logic        an;
        logic        bn;
        logic [63:0] rpre;
    } wia_tag_t;

    function automatic logic [63:0] wia_mask(input logic [6:0] w);
        logic [63:0] m;
        m = ~({64{1'b1}} << w[5:0]);
        if (w[6]) begin
            m = {64{1'b1}};
        end
        return m;
    endfunction

    // sign-extend x from bit w-1; w in 1..64
    function automatic logic [63:0] wia_sext(input logic [63:0] x, input logic [6:0] w);
        logic [63:0] m;
        logic [6:0]  wm1;
        logic        sgn;
        m   = wia_mask(w);
        wm1 = w - 7'd1;
        sgn = x[wm1[5:0]];
        return (x & m) | (sgn ? ~m : 64'd0);
    endfunction

endpackage
`default_nettype wire

// File: hdl/wia_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wia_mul
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 parts.
// ----------------------------------------------------------------------------
module wia_mul (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] prod
);
    import wia_pkg::*;

    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] prod_reg;
    logic [63:0] ll_next;
    logic [63:0] lh_full;
    logic [63:0] hl_full;
    logic [63:0] prod_next;

    always_comb begin
        ll_next = a[31:0] * b[31:0];
        lh_full = a[31:0] * b[63:32];
        hl_full = a[63:32] * b[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= ll_next;
            lh_reg <= lh_full[31:0];
            hl_reg <= hl_full[31:0];
        end
    end

    assign prod_next = ll_reg + {lh_reg + hl_reg, 32'd0};

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// File: hdl/wia_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wia_div
// Pipelined restoring divider, one quotient bit per stage, with a narrow
// side divider in the first stages that reduces the shift count modulo width.
// ----------------------------------------------------------------------------
module wia_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [63:0]         dividend,
    input  logic [63:0]         divisor,
    input  logic [31:0]         sh_val,
    input  logic [6:0]          sh_div,
    input  wia_pkg::wia_tag_t   in_tag,
    output logic                out_valid,
    output logic [63:0]         quot,
    output logic [63:0]         rem,
    output logic [6:0]          sh_rem,
    output wia_pkg::wia_tag_t   out_tag
);
    import wia_pkg::*;

    localparam int DS = WIA_DIV_STAGES;

    logic        v_reg    [0:DS-1];
    logic [63:0] rem_reg  [0:DS-1];
    logic [63:0] dvd_reg  [0:DS-1];
    logic [63:0] dvs_reg  [0:DS-1];
    logic [6:0]  arem_reg [0:DS-1];
    logic [31:0] aval_reg [0:DS-1];
    logic [6:0]  adiv_reg [0:DS-1];
    wia_tag_t    tag_reg  [0:DS-1];

    for (genvar k = 0; k < DS; k++) begin : g_stage
        logic        v_i;
        logic [63:0] rem_i, dvd_i, dvs_i;
        logic [6:0]  arem_i, adiv_i;
        logic [31:0] aval_i;
        wia_tag_t    tag_i;
        logic [64:0] partial, diff;
        logic        qb;
        logic [63:0] rem_next, dvd_next;
        logic [6:0]  arem_next;
        logic [31:0] aval_next;

        if (k == 0) begin : g_in
            assign v_i    = in_valid;
            assign rem_i  = 64'd0;
            assign dvd_i  = dividend;
            assign dvs_i  = divisor;
            assign arem_i = 7'd0;
            assign aval_i = sh_val;
            assign adiv_i = sh_div;
            assign tag_i  = in_tag;
        end else begin : g_chain
            assign v_i    = v_reg[k-1];
            assign rem_i  = rem_reg[k-1];
            assign dvd_i  = dvd_reg[k-1];
            assign dvs_i  = dvs_reg[k-1];
            assign arem_i = arem_reg[k-1];
            assign aval_i = aval_reg[k-1];
            assign adiv_i = adiv_reg[k-1];
            assign tag_i  = tag_reg[k-1];
        end

        always_comb begin
            partial  = {rem_i, dvd_i[63]};
            diff     = partial - {1'b0, dvs_i};
            qb       = ~diff[64];
            rem_next = qb ? diff[63:0] : partial[63:0];
            dvd_next = {dvd_i[62:0], qb};
        end

        if (k < WIA_SH_STAGES) begin : g_sh
            logic [7:0] ap, ad;
            logic       ab;
            always_comb begin
                ap        = {arem_i, aval_i[31]};
                ad        = {1'b0, adiv_i};
                ab        = ap >= ad;
                arem_next = ab ? 7'(ap - ad) : ap[6:0];
                aval_next = {aval_i[30:0], 1'b0};
            end
        end else begin : g_sh_hold
            assign arem_next = arem_i;
            assign aval_next = aval_i;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                dvd_reg[k]  <= dvd_next;
                dvs_reg[k]  <= dvs_i;
                arem_reg[k] <= arem_next;
                aval_reg[k] <= aval_next;
                adiv_reg[k] <= adiv_i;
                tag_reg[k]  <= tag_i;
            end
        end
    end

    assign out_valid = v_reg[DS-1];
    assign quot      = dvd_reg[DS-1];
    assign rem       = rem_reg[DS-1];
    assign sh_rem    = arem_reg[DS-1];
    assign out_tag   = tag_reg[DS-1];

endmodule
`default_nettype wire

// File: hdl/width_integer_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// width_integer_alu
// Fully pipelined 64-bit integer ALU with a per-beat operand width.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (s_*): s_tuser carries the opcode, s_tdata carries operand A,
//   operand B and the operand width (0 means 32; above DATA_WIDTH saturates).
//   Result beat (m_*): m_tuser[0] is the folded flag, m_tdata the 64-bit
//   result (zero when the fold is refused).
//   From an accepted input beat to m_tvalid a beat passes three front
//   stages (width decode, operand prep / partial products, merge), 64
//   divider stages at one quotient bit each, and the output register.
//   Throughput is one beat per cycle for every opcode while s_tready is high;
//   the 64-stage divider chain sets the depth, 32x32 partial products the multiply stage.
//   Reset (aresetn low, synchronous) drops all beats in flight and empties
//   the output and skid registers.
//   When the receiver stalls, the output register holds its beat and one
//   more beat lands in the skid register; the pipeline then freezes as a
//   whole and s_tready drops until the skid register drains. Nothing is
//   lost or repeated.
// ----------------------------------------------------------------------------
module width_integer_alu #(
    parameter int DATA_WIDTH = wia_pkg::WIA_DATA_WIDTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // [63:0] operand_a, [127:64] operand_b,
                                    // [134:128] op_width, [135] zero
    input  logic [4:0]   s_tuser,   // [4:0] req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // [63:0] result_value
    output logic [0:0]   m_tuser    // [0] folded
);
    import wia_pkg::*;

    localparam logic [6:0] DW = 7'(DATA_WIDTH);

    // global advance: freeze the whole pipe only while the skid slot is taken
    logic en;
    logic skid_valid_reg;
    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    // ---------------- stage A: width decode, masked operands ----------------
    logic [6:0]  raw_w, w0, w_next;
    logic [63:0] m0;
    logic        v_a_reg;
    logic [4:0]  op_a_reg;
    logic [63:0] a_a_reg, b_a_reg, ua_a_reg, ub_a_reg;
    logic [6:0]  w_a_reg;

    always_comb begin
        raw_w  = s_tdata[134:128];
        w0     = (raw_w == 7'd0) ? 7'd32 : raw_w;
        w_next = (w0 > DW) ? DW : w0;
        m0     = wia_mask(w_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
        end else if (en) begin
            v_a_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_a_reg <= s_tuser;
            a_a_reg  <= s_tdata[63:0];
            b_a_reg  <= s_tdata[127:64];
            ua_a_reg <= s_tdata[63:0] & m0;
            ub_a_reg <= s_tdata[127:64] & m0;
            w_a_reg  <= w_next;
        end
    end

    // ---------------- stage B: simple ops, fold checks, divider operands ----
    logic [63:0] mul_prod;

    wia_mul u_mul (
        .aclk (aclk),
        .en   (en),
        .a    (a_a_reg),
        .b    (b_a_reg),
        .prod (mul_prod)
    );

    logic [63:0] sa, sb, rs_next, dvd_next, dvs_next;
    logic        ok_next;
    logic        is_min_neg1;

    always_comb begin
        sa          = wia_sext(a_a_reg, w_a_reg);
        sb          = wia_sext(b_a_reg, w_a_reg);
        is_min_neg1 = (w_a_reg == 7'd64) && (a_a_reg == {1'b1, 63'd0})
                      && (b_a_reg == {64{1'b1}});
        rs_next     = 64'd0;
        ok_next     = 1'b1;
        dvd_next    = ua_a_reg;
        dvs_next    = ub_a_reg;
        case (op_a_reg)
            OP_NEG:  rs_next = wia_sext(64'd0 - a_a_reg, w_a_reg);
            OP_NOT:  rs_next = wia_sext(~a_a_reg, w_a_reg);
            OP_ADD:  rs_next = wia_sext(a_a_reg + b_a_reg, w_a_reg);
            OP_SUB:  rs_next = wia_sext(a_a_reg - b_a_reg, w_a_reg);
            OP_MUL:  rs_next = 64'd0;
            OP_DIV_S, OP_REM_S: begin
                ok_next  = (b_a_reg != 64'd0) && !(op_a_reg == OP_DIV_S && is_min_neg1);
                dvd_next = a_a_reg[63] ? 64'd0 - a_a_reg : a_a_reg;
                dvs_next = b_a_reg[63] ? 64'd0 - b_a_reg : b_a_reg;
            end
            OP_DIV_U, OP_REM_U: ok_next = (ub_a_reg != 64'd0);
            OP_AND:  rs_next = a_a_reg & b_a_reg;
            OP_OR:   rs_next = a_a_reg | b_a_reg;
            OP_XOR:  rs_next = a_a_reg ^ b_a_reg;
            OP_SHL:  rs_next = a_a_reg;
            OP_SHR, OP_ROTL, OP_ROTR: rs_next = ua_a_reg;
            OP_SAR:  rs_next = sa;
            OP_EQ:   rs_next = {63'd0, sa == sb};
            OP_NE:   rs_next = {63'd0, sa != sb};
            OP_LT_S: rs_next = {63'd0, $signed(sa) <  $signed(sb)};
            OP_LT_U: rs_next = {63'd0, ua_a_reg <  ub_a_reg};
            OP_LE_S: rs_next = {63'd0, $signed(sa) <= $signed(sb)};
            OP_LE_U: rs_next = {63'd0, ua_a_reg <= ub_a_reg};
            OP_GT_S: rs_next = {63'd0, $signed(sa) >  $signed(sb)};
            OP_GT_U: rs_next = {63'd0, ua_a_reg >  ub_a_reg};
            OP_GE_S: rs_next = {63'd0, $signed(sa) >= $signed(sb)};
            OP_GE_U: rs_next = {63'd0, ua_a_reg >= ub_a_reg};
            default: ok_next = 1'b0;
        endcase
    end

    logic        v_b_reg, ok_b_reg, an_b_reg, bn_b_reg;
    logic [4:0]  op_b_reg;
    logic [6:0]  w_b_reg;
    logic [63:0] rs_b_reg, dvd_b_reg, dvs_b_reg;
    logic [31:0] shv_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_b_reg <= 1'b0;
        end else if (en) begin
            v_b_reg <= v_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_b_reg  <= op_a_reg;
            w_b_reg   <= w_a_reg;
            ok_b_reg  <= ok_next;
            an_b_reg  <= a_a_reg[63];
            bn_b_reg  <= b_a_reg[63];
            rs_b_reg  <= rs_next;
            dvd_b_reg <= dvd_next;
            dvs_b_reg <= dvs_next;
            shv_b_reg <= b_a_reg[31:0];
        end
    end

    // ---------------- stage C: align with the multiplier output -------------
    logic        v_c_reg, ok_c_reg, an_c_reg, bn_c_reg;
    logic [4:0]  op_c_reg;
    logic [6:0]  w_c_reg;
    logic [63:0] rs_c_reg, dvd_c_reg, dvs_c_reg;
    logic [31:0] shv_c_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_c_reg <= 1'b0;
        end else if (en) begin
            v_c_reg <= v_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_c_reg  <= op_b_reg;
            w_c_reg   <= w_b_reg;
            ok_c_reg  <= ok_b_reg;
            an_c_reg  <= an_b_reg;
            bn_c_reg  <= bn_b_reg;
            rs_c_reg  <= rs_b_reg;
            dvd_c_reg <= dvd_b_reg;
            dvs_c_reg <= dvs_b_reg;
            shv_c_reg <= shv_b_reg;
        end
    end

    wia_tag_t c_tag;
    always_comb begin
        c_tag.op   = op_c_reg;
        c_tag.w    = w_c_reg;
        c_tag.ok   = ok_c_reg;
        c_tag.an   = an_c_reg;
        c_tag.bn   = bn_c_reg;
        c_tag.rpre = (op_c_reg == OP_MUL) ? mul_prod : rs_c_reg;
    end

    // ---------------- divider chain, shift count reduced alongside ----------
    logic        d_valid;
    logic [63:0] d_quot, d_rem;
    logic [6:0]  d_sh;
    wia_tag_t    d_tag;

    wia_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v_c_reg),
        .dividend  (dvd_c_reg),
        .divisor   (dvs_c_reg),
        .sh_val    (shv_c_reg),
        .sh_div    (w_c_reg),
        .in_tag    (c_tag),
        .out_valid (d_valid),
        .quot      (d_quot),
        .rem       (d_rem),
        .sh_rem    (d_sh),
        .out_tag   (d_tag)
    );

    // ---------------- result select ----------------
    logic [5:0]  sh;
    logic [6:0]  wsh;
    logic [63:0] pre, res_next;
    logic        need_sext;

    always_comb begin
        sh        = d_sh[5:0];
        wsh       = d_tag.w - {1'b0, sh};
        pre       = d_tag.rpre;
        need_sext = 1'b1;
        case (d_tag.op)
            OP_MUL:   pre = d_tag.rpre;
            OP_DIV_S: pre = (d_tag.an ^ d_tag.bn) ? 64'd0 - d_quot : d_quot;
            OP_DIV_U: pre = d_quot;
            OP_REM_S: pre = d_tag.an ? 64'd0 - d_rem : d_rem;
            OP_REM_U: pre = d_rem;
            OP_SHL:   pre = d_tag.rpre << sh;
            OP_SHR:   pre = d_tag.rpre >> sh;
            OP_SAR:   pre = $unsigned($signed(d_tag.rpre) >>> sh);
            OP_ROTL:  pre = (d_tag.rpre << sh) | (d_tag.rpre >> wsh);
            OP_ROTR:  pre = (d_tag.rpre >> sh) | (d_tag.rpre << wsh);
            default:  need_sext = 1'b0;
        endcase
        if (!d_tag.ok) begin
            res_next = 64'd0;
        end else if (need_sext) begin
            res_next = wia_sext(pre, d_tag.w);
        end else begin
            res_next = pre;
        end
    end

    // ---------------- output register with skid slot ----------------
    logic        push;
    logic        out_valid_reg;
    logic [63:0] out_data_reg, skid_data_reg;
    logic        out_flag_reg, skid_flag_reg;

    assign push = en & d_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            // drain the skid slot first, else take the beat leaving the pipe
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_flag_reg <= skid_flag_reg;
            end else begin
                out_data_reg <= res_next;
                out_flag_reg <= d_tag.ok;
            end
        end else if (push) begin
            skid_data_reg <= res_next;
            skid_flag_reg <= d_tag.ok;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_flag_reg;

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives opcode/operand beats into the width integer ALU, takes each folded
// flag and result from a typed-in expectation or from fold_alu in
// SystemVerilog, and checks them in order. Runs a directed table first, then
// random beats with random idling and one long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
    import wia_pkg::*;

    localparam int LATENCY   = 68;
    localparam int N_RANDOM  = 430;
    localparam int WD_LIMIT  = 2000;

    // one directed row; chk_lit set when the expectation is typed in
    typedef struct {
        logic [4:0]  op;
        logic [63:0] a;
        logic [63:0] b;
        logic [6:0]  w;
        logic        chk_lit;
        logic        lit_ok;
        logic [63:0] lit_val;
    } alu_row_t;

    typedef struct {
        logic        ok;
        logic [63:0] val;
    } alu_res_t;

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;   // [63:0] operand_a, [127:64] operand_b, [134:128] op_width
    logic [4:0]   s_tuser;   // [4:0] req_type
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // [63:0] result_value
    logic [0:0]   m_tuser;   // [0] folded

    alu_res_t results_due[$];
    int       errors;
    logic     feed_done;
    logic     quiet;       // no idling in the last part
    logic     hold_rx;     // long receiver hold-off
    int       idle_cycles;

    width_integer_alu dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [63:0] sx(input logic [63:0] x, input int w);
        logic [63:0] r;
        r = x;
        for (int i = w; i < 64; i++) r[i] = x[w-1];
        return r;
    endfunction

    function automatic logic [63:0] mk(input logic [63:0] x, input int w);
        logic [63:0] r;
        r = x;
        for (int i = w; i < 64; i++) r[i] = 1'b0;
        return r;
    endfunction

    // fold one beat: flag plus result, zero when refused
    function automatic alu_res_t fold_alu(input logic [4:0] op, input logic [63:0] a,
                                          input logic [63:0] b, input logic [6:0] wr);
        alu_res_t    res;
        int          w, sh;
        logic [63:0] ua, ub, q, ma, mb, r;
        logic signed [63:0] sa, sb;
        logic        an, bn;
        w = (wr == 0) ? 32 : ((wr > 64) ? 64 : int'(wr));
        sh = int'(b[31:0] % w);
        ua = mk(a, w);
        ub = mk(b, w);
        sa = sx(a, w);
        sb = sx(b, w);
        an = a[63];
        bn = b[63];
        ma = an ? -a : a;
        mb = bn ? -b : b;
        r = '0;
        res.ok = 1'b1;
        case (op)
            OP_NEG:  r = sx(-a, w);
            OP_NOT:  r = sx(~a, w);
            OP_ADD:  r = sx(a + b, w);
            OP_SUB:  r = sx(a - b, w);
            OP_MUL:  r = sx(a * b, w);
            OP_DIV_S: begin
                if (b == 0 || (w == 64 && a == MIN64 && b == ONES)) res.ok = 1'b0;
                else begin
                    q = ma / mb;
                    if (an != bn) q = -q;
                    r = sx(q, w);
                end
            end
            OP_DIV_U: begin
                if (ub == 0) res.ok = 1'b0;
                else r = sx(ua / ub, w);
            end
            OP_REM_S: begin
                if (b == 0) res.ok = 1'b0;
                else begin
                    q = ma % mb;
                    if (an) q = -q;
                    r = sx(q, w);
                end
            end
            OP_REM_U: begin
                if (ub == 0) res.ok = 1'b0;
                else r = sx(ua % ub, w);
            end
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_SHL:  r = sx(a << sh, w);
            OP_SHR:  r = sx(ua >> sh, w);
            OP_SAR:  r = sx($signed(sx(a, w)) >>> sh, w);
            OP_ROTL: r = sx((sh == 0) ? ua : ((ua << sh) | (ua >> (w - sh))), w);
            OP_ROTR: r = sx((sh == 0) ? ua : ((ua >> sh) | (ua << (w - sh))), w);
            OP_EQ:   r = {63'd0, sa == sb};
            OP_NE:   r = {63'd0, sa != sb};
            OP_LT_S: r = {63'd0, sa < sb};
            OP_LT_U: r = {63'd0, ua < ub};
            OP_LE_S: r = {63'd0, sa <= sb};
            OP_LE_U: r = {63'd0, ua <= ub};
            OP_GT_S: r = {63'd0, sa > sb};
            OP_GT_U: r = {63'd0, ua > ub};
            OP_GE_S: r = {63'd0, sa >= sb};
            OP_GE_U: r = {63'd0, ua >= ub};
            default: res.ok = 1'b0;
        endcase
        res.val = res.ok ? r : 64'd0;
        return res;
    endfunction

    alu_row_t dir_rows[] = '{
        '{OP_ADD,  ONES, 64'd1, 7'd64, 1, 1, 64'd0},
        '{OP_ADD,  64'h7FFF_FFFF, 64'd1, 7'd0, 1, 1, 64'hFFFF_FFFF_8000_0000},
        '{OP_NEG,  MIN64, 64'd0, 7'd64, 1, 1, MIN64},
        '{OP_NOT,  64'd0, 64'd0, 7'd1, 1, 1, ONES},
        '{OP_SUB,  64'd0, 64'd1, 7'd127, 1, 1, ONES},
        '{OP_MUL,  ONES, ONES, 7'd64, 1, 1, 64'd1},
        '{OP_DIV_S, 64'd5, 64'd0, 7'd64, 1, 0, 64'd0},
        '{OP_DIV_S, MIN64, ONES, 7'd64, 1, 0, 64'd0},
        '{OP_DIV_S, MIN64, ONES, 7'd32, 0, 0, 64'd0},
        '{OP_DIV_U, 64'd7, 64'h1_0000_0000, 7'd32, 1, 0, 64'd0},
        '{OP_REM_S, MIN64, ONES, 7'd64, 1, 1, 64'd0},
        '{OP_REM_S, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 7'd64, 1, 1, ONES},
        '{OP_REM_U, 64'd9, 64'd0, 7'd8, 1, 0, 64'd0},
        '{OP_AND,  ONES, 64'hA5A5, 7'd3, 1, 1, 64'hA5A5},
        '{OP_OR,   MIN64, 64'd1, 7'd1, 1, 1, 64'h8000_0000_0000_0001},
        '{OP_XOR,  ONES, ONES, 7'd64, 1, 1, 64'd0},
        '{OP_SHL,  64'd1, 64'd63, 7'd64, 1, 1, MIN64},
        '{OP_SHR,  ONES, 64'h1_0000_0004, 7'd64, 0, 0, 64'd0},
        '{OP_SAR,  64'h80, 64'd3, 7'd8, 1, 1, 64'hFFFF_FFFF_FFFF_FFF0},
        '{OP_ROTL, 64'h81, 64'd1, 7'd8, 0, 0, 64'd0},
        '{OP_ROTR, 64'd1, 64'd65, 7'd64, 1, 1, MIN64},
        '{OP_EQ,   64'hFF, ONES, 7'd8, 1, 1, 64'd1},
        '{OP_LT_S, MIN64, 64'd0, 7'd64, 1, 1, 64'd1},
        '{OP_GE_U, 64'd0, ONES, 7'd64, 1, 1, 64'd0},
        '{5'd31,   64'd1, 64'd1, 7'd64, 1, 0, 64'd0}
    };

    // present one beat and hold it until the handshake
    task automatic send_beat(input logic [4:0] op, input logic [63:0] a,
                             input logic [63:0] b, input logic [6:0] w);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, w, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic idle_burst();
        if (!quiet && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
    endtask

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return 64'($urandom_range(16));
            2: return -64'($urandom_range(16, 1));
            3: return MIN64 ^ 64'($urandom_range(1));
            4: return 64'(1) << $urandom_range(63);
            default: return {32'($signed($urandom) >>> 31), $urandom};
        endcase
    endfunction

    // sender
    initial begin
        alu_res_t    p;
        logic [4:0]  op;
        logic [6:0]  w;
        logic [63:0] a, b;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        feed_done = 1'b0;
        quiet     = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].chk_lit) begin
                p.ok  = dir_rows[i].lit_ok;
                p.val = dir_rows[i].lit_val;
            end else begin
                p = fold_alu(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].w);
            end
            results_due.push_back(p);
            send_beat(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].w);
            idle_burst();
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 60) quiet = 1'b1;
            op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 27))
                                           : 5'($urandom_range(26));
            case ($urandom_range(4))
                0: w = 7'd64;
                1: w = 7'd0;
                2: w = 7'($urandom_range(127, 65));
                default: w = 7'($urandom_range(64, 1));
            endcase
            a = pick_operand();
            b = ($urandom_range(9) == 0) ? 64'd0 : pick_operand();
            results_due.push_back(fold_alu(op, a, b, w));
            send_beat(op, a, b, w);
            idle_burst();
        end
        s_tvalid  <= 1'b0;
        feed_done <= 1'b1;
    end

    // receiver: random stalls, plus one long hold-off mid-run
    initial begin
        hold_rx <= 1'b0;
        @(posedge aclk iff aresetn);
        repeat (150) @(posedge aclk);
        hold_rx <= 1'b1;
        repeat (200) @(posedge aclk);
        hold_rx <= 1'b0;
    end

    always @(posedge aclk) begin
        if (hold_rx) begin
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(4) == 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // scoreboard: pop the oldest prediction per result beat
    always @(posedge aclk) begin
        alu_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $display("%0t: result beat with nothing due: folded %0b value %h",
                         $realtime, m_tuser[0], m_tdata);
                errors++;
            end else begin
                e = results_due.pop_front();
                if (m_tuser[0] !== e.ok) begin
                    $display("%0t: folded expected %0b actual %0b",
                             $realtime, e.ok, m_tuser[0]);
                    errors++;
                end
                if (m_tdata !== e.val) begin
                    $display("%0t: result expected %h actual %h",
                             $realtime, e.val, m_tdata);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        fork
            begin
                wait (feed_done && results_due.size() == 0);
                repeat (LATENCY + 10) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= WD_LIMIT);
                $display("%0t: watchdog expired, %0d results outstanding",
                         $realtime, results_due.size());
            end
        join_any
        if (errors == 0 && idle_cycles < WD_LIMIT) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/wia_pkg.sv
hdl/wia_mul.sv
hdl/wia_div.sv
hdl/width_integer_alu.sv
tb/testbench.sv
